/* rtl/mbp_pkg.sv */
// Package for the MSB-first bit packer: sizes, operation codes and the
// item format carried from the front stage through the queue to the back end.
// No dependencies.
package mbp_pkg;

   localparam int MAX_FIELD_BITS = 32;
   localparam int VALUE_BITS     = 32;
   localparam int FIELD_LIMIT    = (MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;
   localparam int BYTE_BITS      = 8;
   localparam int COUNT_BITS     = 6;
   localparam int PEND_BITS      = BYTE_BITS - 1;
   localparam int CNT_W          = $clog2(BYTE_BITS);
   localparam int WORD_BITS      = VALUE_BITS + BYTE_BITS;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
   localparam int REM_BITS       = 3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic                    func;
      logic [VALUE_BITS-1:0]   fld;
      logic [COUNT_BITS-1:0]   cnt;
   } item_type;

endpackage

/* rtl/mbp_front.sv */
// Front stage of the bit packer: takes request beats, saturates the count,
// left-justifies the field, drops zero-length writes. Depends on mbp_pkg.
module mbp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_func,
   input  logic [mbp_pkg::VALUE_BITS-1:0] req_value,
   input  logic [mbp_pkg::COUNT_BITS-1:0] req_bit_count,
   output logic                          q_push,
   output mbp_pkg::item_type             q_item,
   input  logic                          q_full
);
   import mbp_pkg::*;

   logic                  valid_ff, valid_in;
   item_type              item_ff, item_in;
   logic [COUNT_BITS-1:0] cnt_sat;
   logic                  take;
   logic                  keep;

   assign req_full = valid_ff && q_full;
   assign take     = req_push && !req_full;
   assign q_push   = valid_ff;
   assign q_item   = item_ff;

   always_comb begin
      cnt_sat = (req_bit_count > COUNT_BITS'(FIELD_LIMIT)) ? COUNT_BITS'(FIELD_LIMIT)
                                                          : req_bit_count;
      item_in.func = req_func;
      item_in.cnt  = cnt_sat;
      if (req_func == OP_FLUSH) begin
         item_in.fld = {VALUE_BITS{req_value[0]}};
      end else begin
         item_in.fld = req_value << (COUNT_BITS'(VALUE_BITS) - cnt_sat);
      end
      keep = (req_func == OP_FLUSH) || (cnt_sat != '0);
      if (take) begin
         valid_in = keep;
      end else begin
         valid_in = valid_ff && q_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/mbp_queue.sv */
// Short item queue between the front stage and the back end of the packer.
// Depends on mbp_pkg.
module mbp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mbp_pkg::item_type push_item,
   output logic              full,
   output logic              valid,
   output mbp_pkg::item_type head_item,
   input  logic              pop
);
   import mbp_pkg::*;

   item_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]     fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign full      = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign valid     = (fill_ff != '0);
   assign head_item = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wr_in = (wr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

/* rtl/mbp_back.sv */
// Back end of the bit packer: merges queued fields with the pending bits, emits whole
// bytes one per cycle into the result register unless the receiver stalls. Depends on mbp_pkg.
module mbp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  mbp_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [mbp_pkg::BYTE_BITS-1:0] rsp_out_byte,
   output logic              rsp_last
);
   import mbp_pkg::*;

   logic [PEND_BITS-1:0] pend_ff, pend_in;
   logic [CNT_W-1:0]     pcnt_ff, pcnt_in;
   logic [WORD_BITS-1:0] wrk_ff, wrk_in, word;
   logic [REM_BITS-1:0]  rem_ff, rem_in, nbytes;
   logic [COUNT_BITS-1:0] total;
   logic                 ovld_ff, ovld_in;
   logic [BYTE_BITS-1:0] obyte_ff;
   logic                 olast_ff;
   logic                 emit, load, skip;

   assign rsp_empty    = !ovld_ff;
   assign rsp_out_byte = obyte_ff;
   assign rsp_last     = olast_ff;

   assign emit  = (rem_ff != '0) && (!ovld_ff || rsp_pop);
   assign load  = q_valid && ((rem_ff == '0) || ((rem_ff == REM_BITS'(1)) && emit));
   assign q_pop = load;
   assign skip  = (q_item.func == OP_FLUSH) && (pcnt_ff == '0);

   always_comb begin
      word  = {pend_ff, {(WORD_BITS-PEND_BITS){1'b0}}}
            | ({q_item.fld, {BYTE_BITS{1'b0}}} >> pcnt_ff);
      total = COUNT_BITS'(pcnt_ff) + q_item.cnt;
      if (q_item.func == OP_FLUSH) begin
         nbytes  = REM_BITS'(1);
         pend_in = '0;
         pcnt_in = '0;
      end else begin
         nbytes  = REM_BITS'(total >> CNT_W);
         pcnt_in = total[CNT_W-1:0];
         case (nbytes)
            3'd0:    pend_in = word[39:33];
            3'd1:    pend_in = word[31:25];
            3'd2:    pend_in = word[23:17];
            3'd3:    pend_in = word[15:9];
            default: pend_in = word[7:1];
         endcase
      end

      wrk_in = wrk_ff;
      rem_in = rem_ff;
      if (emit) begin
         wrk_in = wrk_ff << BYTE_BITS;
         rem_in = rem_ff - 1'b1;
      end
      if (load && !skip) begin
         wrk_in = word;
         rem_in = nbytes;
      end else begin
         pend_in = pend_ff;
         pcnt_in = pcnt_ff;
      end

      if (emit) begin
         ovld_in = 1'b1;
      end else if (rsp_pop) begin
         ovld_in = 1'b0;
      end else begin
         ovld_in = ovld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         pcnt_ff <= '0;
         rem_ff  <= '0;
         ovld_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         pcnt_ff <= pcnt_in;
         rem_ff  <= rem_in;
         ovld_ff <= ovld_in;
      end
      wrk_ff <= wrk_in;
      if (emit) begin
         obyte_ff <= wrk_ff[WORD_BITS-1 -: BYTE_BITS];
         olast_ff <= (rem_ff == REM_BITS'(1));
      end
   end

endmodule

/* rtl/msb_first_bit_packer.sv */
// MSB-first variable-length bit packer: top level joining the front stage,
// the item queue and the byte-emitting back end. Depends on mbp_pkg.
//
// Request side is a queue write port: a beat moves when req_push is high
// and req_full is low. func 0 appends the low bit_count bits of value
// (count saturated to 32), most significant first; func 1 pads the partial
// byte with value bit 0 and emits it if any bits were pending.
// Response side is a queue read port: a byte waits on rsp_out_byte/rsp_last
// while rsp_empty is low and leaves when rsp_pop is high. rsp_last marks the
// final byte caused by one request beat.
// A beat passes the front register, a queue slot and the back end's work register
// before its first byte reaches the result register. The back end emits one byte
// per cycle unless the receiver stalls; a 32-bit field yields up to 4 bytes, and
// a two-entry queue and the front register absorb short beats.
// Reset clears pending bits, the queue and the result register.
// When the receiver stalls, the result register holds, the back end stops,
// and the queue fills until req_full rises.
module msb_first_bit_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_func,
   input  logic [mbp_pkg::VALUE_BITS-1:0] req_value,
   input  logic [mbp_pkg::COUNT_BITS-1:0] req_bit_count,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [mbp_pkg::BYTE_BITS-1:0] rsp_out_byte,
   output logic                          rsp_last
);
   import mbp_pkg::*;

   logic     f_push, f_full, q_valid, q_pop;
   item_type f_item, q_item;

   mbp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_func      (req_func),
      .req_value     (req_value),
      .req_bit_count (req_bit_count),
      .q_push        (f_push),
      .q_item        (f_item),
      .q_full        (f_full)
   );

   mbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .full      (f_full),
      .valid     (q_valid),
      .head_item (q_item),
      .pop       (q_pop)
   );

   mbp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for msb_first_bit_packer: queue-style driver and monitor,
// with a bit-level packing predictor and an in-order expected-byte queue.
// Depends on mbp_pkg and the msb_first_bit_packer RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mbp_pkg::*;

   localparam int ITEM_TARGET = 140;
   localparam int BURST_LEN   = 30;
   localparam int STALL_LEN   = 240;
   localparam int IDLE_LIMIT  = 4000;
   localparam int SETTLE      = 40;

   typedef struct {
      logic                  func;
      logic [VALUE_BITS-1:0] value;
      logic [COUNT_BITS-1:0] count;
      int                    gap;
      bit                    drain;
   } field_req_type;

   typedef struct {
      logic [BYTE_BITS-1:0] data;
      logic                 last;
   } packed_byte_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic                  req_func = OP_WRITE;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic [COUNT_BITS-1:0] req_bit_count = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [BYTE_BITS-1:0]  rsp_out_byte;
   logic                  rsp_last;

   field_req_type   field_q[$];
   packed_byte_type due_bytes[$];

   logic [PEND_BITS-1:0] pend_bits = '0;
   logic [CNT_W-1:0]     pend_cnt  = '0;

   int bytes_predicted = 0;
   int bytes_popped    = 0;
   int items_taken     = 0;
   int mismatches      = 0;
   int burst_at        = 32'h7fff_ffff;
   int tx_gap          = 0;
   int rx_hold         = 0;
   bit rx_calm         = 1'b0;
   bit rx_stalled      = 1'b0;
   bit tx_calm         = 1'b0;
   int idle_cycles     = 0;

   msb_first_bit_packer dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_func      (req_func),
      .req_value     (req_value),
      .req_bit_count (req_bit_count),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                  input longint unsigned got_v);
      $display("%0t ns mismatch %s: expected %0h, got %0h", $time, what, exp_v, got_v);
      mismatches++;
   endtask

   // shift one bit into the partial byte; return 1 with the byte when eight have gathered
   function automatic logic shift_bit(input logic b, output logic [BYTE_BITS-1:0] done);
      logic [BYTE_BITS-1:0] acc;
      acc  = {pend_bits, b};
      done = acc;
      if (pend_cnt == CNT_W'(PEND_BITS)) begin
         pend_bits = '0;
         pend_cnt  = '0;
         return 1'b1;
      end
      pend_bits = acc[PEND_BITS-1:0];
      pend_cnt  = pend_cnt + 1'b1;
      return 1'b0;
   endfunction

   function automatic void pack_field(input field_req_type it);
      logic [BYTE_BITS-1:0] b;
      logic [BYTE_BITS-1:0] made[$];
      int                   n;
      packed_byte_type      nb;
      if (it.func == OP_FLUSH) begin
         while (pend_cnt != 0)
            if (shift_bit(it.value[0], b)) made.insert(made.size(), b);
      end else begin
         n = (int'(it.count) > FIELD_LIMIT) ? FIELD_LIMIT : int'(it.count);
         for (int i = n - 1; i >= 0; i--)
            if (shift_bit(it.value[i], b)) made.insert(made.size(), b);
      end
      foreach (made[k]) begin
         nb = '{data: made[k], last: (k == made.size() - 1)};
         due_bytes.insert(due_bytes.size(), nb);
         bytes_predicted++;
      end
   endfunction

   function automatic int next_gap();
      if ($urandom_range(0, 11) == 0) tx_calm = !tx_calm;
      return tx_calm ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic void queue_field(input logic func, input logic [VALUE_BITS-1:0] value,
                                       input int count, input int gap, input bit drain);
      field_req_type fr;
      fr = '{func: func, value: value, count: COUNT_BITS'(count), gap: gap, drain: drain};
      field_q.insert(field_q.size(), fr);
   endfunction

   // driver
   always @(posedge clock) begin
      logic          fire;
      field_req_type cur;
      if (reset) begin
         req_push <= 1'b0;
         tx_gap = 0;
      end else begin
         fire = req_push && !req_full;
         if (fire) begin
            cur = '{func: req_func, value: req_value, count: req_bit_count, gap: 0, drain: 0};
            pack_field(cur);
            void'(field_q.pop_front());
            items_taken <= items_taken + 1;
            if (field_q.size() != 0) tx_gap = field_q[0].gap;
         end
         if (!req_push || fire) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_push <= 1'b0;
            end else if (field_q.size() != 0 &&
                         (!field_q[0].drain || bytes_predicted == bytes_popped)) begin
               req_push      <= 1'b1;
               req_func      <= field_q[0].func;
               req_value     <= field_q[0].value;
               req_bit_count <= field_q[0].count;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      packed_byte_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         rx_hold = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (due_bytes.size() == 0) begin
               report_mismatch("unexpected beat", 0, rsp_out_byte);
            end else begin
               want = due_bytes.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch("out_byte", want.data, rsp_out_byte);
               if (rsp_last !== want.last)
                  report_mismatch("last", want.last, rsp_last);
               bytes_popped <= bytes_popped + 1;
            end
            if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
            rx_hold = rx_calm ? 0 : $urandom_range(0, 17);
         end
         if (!rx_stalled && items_taken >= burst_at + 2) begin
            rx_hold    = STALL_LEN;
            rx_stalled = 1'b1;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                    fields_made;
      int                    r;
      int                    cnt;
      logic                  func;
      logic [VALUE_BITS-1:0] value;

      queue_field(OP_WRITE, 32'hFFFF_FFFF, 0, next_gap(), 0);
      queue_field(OP_FLUSH, 32'hFFFF_FFFF, 63, next_gap(), 0);
      queue_field(OP_WRITE, 32'h0000_00A5, 8, next_gap(), 0);
      queue_field(OP_WRITE, 32'hFFFF_FFFF, 32, next_gap(), 0);
      queue_field(OP_WRITE, 32'h0000_0000, 32, next_gap(), 0);
      queue_field(OP_WRITE, 32'h0000_0001, 1, next_gap(), 0);
      queue_field(OP_FLUSH, 32'h0000_0000, 0, next_gap(), 0);
      queue_field(OP_WRITE, 32'h0000_0005, 3, next_gap(), 1);
      queue_field(OP_FLUSH, 32'hFFFF_FFFF, 63, next_gap(), 0);
      queue_field(OP_FLUSH, 32'h0000_0001, 5, next_gap(), 0);
      queue_field(OP_WRITE, 32'h0000_007F, 7, next_gap(), 0);
      queue_field(OP_FLUSH, 32'hFFFF_FFFE, 63, next_gap(), 0);
      queue_field(OP_WRITE, 32'h0000_0055, 7, next_gap(), 0);
      queue_field(OP_WRITE, 32'hFFFF_FFFF, 1, next_gap(), 0);
      queue_field(OP_WRITE, 32'h0000_0003, 5, next_gap(), 0);
      queue_field(OP_WRITE, 32'h89AB_CDEF, 63, next_gap(), 0);
      queue_field(OP_WRITE, 32'h1234_5678, 33, next_gap(), 0);
      queue_field(OP_WRITE, $urandom, 31, next_gap(), 0);
      queue_field(OP_FLUSH, 32'h0000_0001, 0, next_gap(), 0);
      queue_field(OP_WRITE, 32'h8000_0001, 32, 0, 0);
      queue_field(OP_WRITE, 32'hFFFF_FFFF, 7, 0, 0);
      queue_field(OP_FLUSH, 32'h0000_0000, 0, 0, 1);

      fields_made = 0;
      while (fields_made < ITEM_TARGET) begin
         if (fields_made == 60) begin
            // back-to-back wide writes while the receiver holds off
            burst_at = field_q.size();
            repeat (BURST_LEN) queue_field(OP_WRITE, $urandom, $urandom_range(24, 32), 0, 0);
            queue_field(OP_FLUSH, $urandom, $urandom_range(0, 63), next_gap(), 1);
            fields_made += BURST_LEN + 1;
         end
         r     = $urandom_range(0, 99);
         value = $urandom;
         func  = (r < 15) ? OP_FLUSH : OP_WRITE;
         if (r < 15)      cnt = $urandom_range(0, 63);
         else if (r < 85) cnt = $urandom_range(1, 32);
         else if (r < 92) cnt = 0;
         else             cnt = $urandom_range(33, 63);
         queue_field(func, value, cnt, next_gap(), $urandom_range(0, 24) == 0);
         if (func == OP_FLUSH || cnt != 0) fields_made++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (field_q.size() != 0 || req_push) @(posedge clock);
      while (bytes_popped != bytes_predicted) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (due_bytes.size() != 0)
         report_mismatch("bytes never delivered", due_bytes.size(), 0);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/mbp_pkg.sv
rtl/mbp_front.sv
rtl/mbp_queue.sv
rtl/mbp_back.sv
rtl/msb_first_bit_packer.sv
verif/tb_top.sv
